### sv/ffba_pkg.sv
// Shared types, constants and helpers for the first-fit block allocator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ffba_pkg;

    localparam int SLOT_COUNT    = 64;
    localparam int IDX_W         = $clog2(SLOT_COUNT);
    localparam int CNT_W         = IDX_W + 1;
    localparam int OFF_W         = 20;
    localparam int LEN_W         = 21;
    localparam int SIZE_W        = 22;
    localparam int AGE_W         = 16;
    localparam int KB_W          = 11;
    localparam int GRANULE_BYTES = 8;
    localparam int KBYTE_SHIFT   = 10;
    localparam int MAX_POOL_KB   = 1024;
    localparam int POOL_KB_RESET = 64;

    localparam logic [AGE_W-1:0] AGE_LIMIT = 16'hFFFF;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESIZE = 2'd2;

    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_TOO_LARGE    = 3'd1,
        STAT_NO_FIT       = 3'd2,
        STAT_TABLE_FULL   = 3'd3,
        STAT_UNKNOWN_ADDR = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_BAD,
        OP_ALLOC,
        OP_FREE,
        OP_RESIZE
    } op_t;

    typedef enum logic [1:0] {
        PASS_FIND_USED,
        PASS_BEST,
        PASS_NEIGH,
        PASS_RANK
    } pass_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_FOUND,
        S_ALLOC_DEC,
        S_AGE,
        S_RANK_END,
        S_EXACT,
        S_SPLIT_W1,
        S_SPLIT_W2,
        S_SHRINK_W1,
        S_SHRINK_W2,
        S_FREE_MERGE,
        S_GROW_DEC,
        S_GROW_W2,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [20:0] request_bytes;
        logic [19:0] block_address;
        logic        address_valid;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] result_address;
        logic        moved;
        logic [20:0] used_bytes;
        logic [20:0] peak_bytes;
    } result_t;

    typedef struct packed {
        op_t               op;
        logic [SIZE_W-1:0] size;
        logic              zero;
        logic [OFF_W-1:0]  addr;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Pool size in bytes; zero counts as one kilobyte, the top is clamped.
    function automatic logic [LEN_W-1:0] pool_bytes(input logic [KB_W-1:0] kb);
        logic [KB_W-1:0] kb_c;
        kb_c = kb;
        if (kb == '0)
        begin
            kb_c = KB_W'(1);
        end
        else if (kb > KB_W'(MAX_POOL_KB))
        begin
            kb_c = KB_W'(MAX_POOL_KB);
        end
        return LEN_W'({kb_c, {KBYTE_SHIFT{1'b0}}});
    endfunction

endpackage

`default_nettype wire

### sv/ffba_queue.sv
// Two-entry job queue between the command front end and the table engine.
// Depends on ffba_pkg for the job type.
`default_nettype none

module ffba_queue
    import ffba_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire job_t      push_job,
    input  wire logic      pop,
    output job_t           head,
    output q_status_t      qstat
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == 2'd0);
    assign qstat.full  = (count_reg == 2'd2);

endmodule

`default_nettype wire

### sv/ffba_front.sv
// Command front end: takes requests, rounds sizes and classifies the operation.
// Depends on ffba_pkg for the request and job types.
`default_nettype none

module ffba_front
    import ffba_pkg::*;
(
    input  wire logic      start,
    input  wire request_t  request,
    input  wire q_status_t qstat,
    input  wire logic      init_busy,
    output logic           busy,
    output logic           push,
    output job_t           job
);

    logic [SIZE_W-1:0] sum;
    logic [SIZE_W-1:0] rounded;

    always_comb
    begin
        sum     = SIZE_W'(request.request_bytes) + SIZE_W'(GRANULE_BYTES - 1);
        rounded = sum & ~SIZE_W'(GRANULE_BYTES - 1);
        if (rounded == '0)
        begin
            rounded = SIZE_W'(GRANULE_BYTES);
        end

        job.size = rounded;
        job.zero = (request.request_bytes == '0);
        job.addr = request.block_address;
        case (request.cmd)
            CMD_ALLOC:  job.op = OP_ALLOC;
            CMD_FREE:   job.op = request.address_valid ? OP_FREE : OP_BAD;
            CMD_RESIZE: job.op = request.address_valid ? OP_RESIZE : OP_ALLOC;
            default:    job.op = OP_NOP;
        endcase
    end

    assign busy = qstat.full || init_busy;
    assign push = start && !busy;

endmodule

`default_nettype wire

### sv/ffba_back.sv
// Table engine: holds the segment table and carries out queued jobs by scans.
// Depends on ffba_pkg for types, constants and state codes.
`default_nettype none

module ffba_back
    import ffba_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [LEN_W-1:0] pool,
    input  wire q_status_t        qstat,
    input  wire job_t             head,
    output logic                  pop,
    output logic                  init_busy,
    output logic                  done,
    output result_t               result
);

    localparam int OL_W = OFF_W + LEN_W;

    // Segment table storage: offset and length in one memory, age in another.
    logic [OL_W-1:0]  offlen_mem [SLOT_COUNT];
    logic [AGE_W-1:0] age_mem    [SLOT_COUNT];

    logic             ol_we;
    logic [IDX_W-1:0] ol_waddr;
    logic [OL_W-1:0]  ol_wdata;
    logic             age_we;
    logic [IDX_W-1:0] age_waddr;
    logic [AGE_W-1:0] age_wdata;
    logic [IDX_W-1:0] rd_addr;
    logic [OL_W-1:0]  rd_ol_reg;
    logic [AGE_W-1:0] rd_age_reg;

    state_t state_reg, state_next;
    state_t after_reg, after_next;
    state_t age_ret_reg, age_ret_next;
    pass_t  mode_reg, mode_next;

    op_t               op_reg, op_next;
    logic [SIZE_W-1:0] s_reg, s_next;
    logic [OFF_W-1:0]  addr_reg, addr_next;
    logic              zero_reg, zero_next;
    logic              move_reg, move_next;
    logic              init_reg, init_next;
    logic              grow_p_reg, grow_p_next;

    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             eval_en_reg, eval_en_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;

    logic             e_found_reg, e_found_next;
    logic [IDX_W-1:0] e_idx_reg, e_idx_next;
    logic [OFF_W-1:0] e_off_reg, e_off_next;
    logic [LEN_W-1:0] e_len_reg, e_len_next;
    logic             spare_found_reg, spare_found_next;
    logic [IDX_W-1:0] spare_idx_reg, spare_idx_next;
    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [OFF_W-1:0] best_off_reg, best_off_next;
    logic [LEN_W-1:0] best_len_reg, best_len_next;
    logic [AGE_W-1:0] best_age_reg, best_age_next;
    logic             p_found_reg, p_found_next;
    logic [IDX_W-1:0] p_idx_reg, p_idx_next;
    logic [OFF_W-1:0] p_off_reg, p_off_next;
    logic [LEN_W-1:0] p_len_reg, p_len_next;
    logic             n_found_reg, n_found_next;
    logic [IDX_W-1:0] n_idx_reg, n_idx_next;
    logic [OFF_W-1:0] n_off_reg, n_off_next;
    logic [LEN_W-1:0] n_len_reg, n_len_next;

    logic             have_m_reg, have_m_next;
    logic [AGE_W-1:0] m_reg, m_next;
    logic             min_found_reg, min_found_next;
    logic [AGE_W-1:0] min_age_reg, min_age_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] base_reg, base_next;

    logic [AGE_W-1:0] next_age_reg, next_age_next;
    logic [AGE_W-1:0] age_val_reg, age_val_next;
    logic [LEN_W-1:0] used_reg, used_next;
    logic [LEN_W-1:0] peak_reg, peak_next;
    status_t          res_status_reg, res_status_next;
    logic [OFF_W-1:0] res_addr_reg, res_addr_next;
    logic             res_moved_reg, res_moved_next;

    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [SLOT_COUNT-1:0] free_reg, free_next;
    logic [SLOT_COUNT-1:0] aged_reg, aged_next;
    logic [SLOT_COUNT-1:0] done_reg, done_next;

    logic              issue;
    logic              pass_end;
    logic              start_pass;
    logic [OFF_W-1:0]  rd_off;
    logic [LEN_W-1:0]  rd_len;
    logic [AGE_W-1:0]  age_eff;
    logic              vld;
    logic              fr;
    logic              do_add;
    logic [LEN_W-1:0]  add_amt;
    logic              do_sub;
    logic [LEN_W-1:0]  sub_amt;
    logic [LEN_W-1:0]  sum;
    logic [SIZE_W-1:0] diff;
    logic              p_ok;
    logic              n_ok;
    logic [LEN_W-1:0]  merged_len;

    always_ff @(posedge clk)
    begin
        if (ol_we)
        begin
            offlen_mem[ol_waddr] <= ol_wdata;
        end
        if (age_we)
        begin
            age_mem[age_waddr] <= age_wdata;
        end
        rd_ol_reg  <= offlen_mem[rd_addr];
        rd_age_reg <= age_mem[rd_addr];
    end

    assign rd_addr  = scan_idx_reg[IDX_W-1:0];
    assign issue    = (state_reg == S_SCAN) && (scan_idx_reg < CNT_W'(SLOT_COUNT));
    assign pass_end = eval_en_reg && (eval_idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign rd_off   = rd_ol_reg[OL_W-1:LEN_W];
    assign rd_len   = rd_ol_reg[LEN_W-1:0];
    assign vld      = valid_reg[eval_idx_reg];
    assign fr       = free_reg[eval_idx_reg];
    assign age_eff  = aged_reg[eval_idx_reg] ? rd_age_reg : '0;
    assign diff     = s_reg - SIZE_W'(e_len_reg);
    assign p_ok     = p_found_reg && free_reg[p_idx_reg];
    assign n_ok     = n_found_reg && free_reg[n_idx_reg];

    always_comb
    begin
        state_next       = state_reg;
        after_next       = after_reg;
        age_ret_next     = age_ret_reg;
        mode_next        = mode_reg;
        op_next          = op_reg;
        s_next           = s_reg;
        addr_next        = addr_reg;
        zero_next        = zero_reg;
        move_next        = move_reg;
        init_next        = init_reg;
        grow_p_next      = grow_p_reg;
        scan_idx_next    = scan_idx_reg;
        eval_en_next     = issue;
        eval_idx_next    = rd_addr;
        e_found_next     = e_found_reg;
        e_idx_next       = e_idx_reg;
        e_off_next       = e_off_reg;
        e_len_next       = e_len_reg;
        spare_found_next = spare_found_reg;
        spare_idx_next   = spare_idx_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_off_next    = best_off_reg;
        best_len_next    = best_len_reg;
        best_age_next    = best_age_reg;
        p_found_next     = p_found_reg;
        p_idx_next       = p_idx_reg;
        p_off_next       = p_off_reg;
        p_len_next       = p_len_reg;
        n_found_next     = n_found_reg;
        n_idx_next       = n_idx_reg;
        n_off_next       = n_off_reg;
        n_len_next       = n_len_reg;
        have_m_next      = have_m_reg;
        m_next           = m_reg;
        min_found_next   = min_found_reg;
        min_age_next     = min_age_reg;
        k_next           = k_reg;
        base_next        = base_reg;
        next_age_next    = next_age_reg;
        age_val_next     = age_val_reg;
        used_next        = used_reg;
        peak_next        = peak_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        res_moved_next   = res_moved_reg;
        valid_next       = valid_reg;
        free_next        = free_reg;
        aged_next        = aged_reg;
        done_next        = done_reg;
        ol_we            = 1'b0;
        ol_waddr         = '0;
        ol_wdata         = '0;
        age_we           = 1'b0;
        age_waddr        = '0;
        age_wdata        = '0;
        pop              = 1'b0;
        start_pass       = 1'b0;
        do_add           = 1'b0;
        add_amt          = '0;
        do_sub           = 1'b0;
        sub_amt          = '0;
        sum              = '0;
        merged_len       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (init_reg)
                begin
                    ol_we       = 1'b1;
                    ol_waddr    = '0;
                    ol_wdata    = {OFF_W'(0), pool};
                    age_we      = 1'b1;
                    age_waddr   = '0;
                    age_wdata   = '0;
                    valid_next[0] = 1'b1;
                    free_next[0]  = 1'b1;
                    aged_next[0]  = 1'b1;
                    init_next   = 1'b0;
                end
                else if (!qstat.empty)
                begin
                    pop             = 1'b1;
                    op_next         = head.op;
                    s_next          = head.size;
                    addr_next       = head.addr;
                    zero_next       = head.zero;
                    move_next       = 1'b0;
                    res_status_next = STAT_OK;
                    res_addr_next   = '0;
                    res_moved_next  = 1'b0;
                    case (head.op)
                        OP_ALLOC:
                        begin
                            if (head.size > SIZE_W'(pool))
                            begin
                                res_status_next = STAT_TOO_LARGE;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                start_pass = 1'b1;
                                mode_next  = PASS_BEST;
                                after_next = S_ALLOC_DEC;
                                state_next = S_SCAN;
                            end
                        end
                        OP_FREE, OP_RESIZE:
                        begin
                            start_pass = 1'b1;
                            mode_next  = PASS_FIND_USED;
                            after_next = S_FOUND;
                            state_next = S_SCAN;
                        end
                        OP_BAD:
                        begin
                            res_status_next = STAT_UNKNOWN_ADDR;
                            state_next      = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (eval_en_reg)
                begin
                    case (mode_reg)
                        PASS_FIND_USED:
                        begin
                            if (!e_found_reg && vld && !fr && rd_off == addr_reg)
                            begin
                                e_found_next = 1'b1;
                                e_idx_next   = eval_idx_reg;
                                e_off_next   = rd_off;
                                e_len_next   = rd_len;
                            end
                            if (!spare_found_reg && !vld)
                            begin
                                spare_found_next = 1'b1;
                                spare_idx_next   = eval_idx_reg;
                            end
                        end
                        PASS_BEST:
                        begin
                            if (vld && fr && SIZE_W'(rd_len) >= s_reg &&
                                (!best_found_reg || age_eff < best_age_reg))
                            begin
                                best_found_next = 1'b1;
                                best_idx_next   = eval_idx_reg;
                                best_off_next   = rd_off;
                                best_len_next   = rd_len;
                                best_age_next   = age_eff;
                            end
                            if (!spare_found_reg && !vld)
                            begin
                                spare_found_next = 1'b1;
                                spare_idx_next   = eval_idx_reg;
                            end
                        end
                        PASS_NEIGH:
                        begin
                            if (eval_idx_reg != e_idx_reg && vld)
                            begin
                                if (!p_found_reg &&
                                    SIZE_W'(rd_off) + SIZE_W'(rd_len) == SIZE_W'(e_off_reg))
                                begin
                                    p_found_next = 1'b1;
                                    p_idx_next   = eval_idx_reg;
                                    p_off_next   = rd_off;
                                    p_len_next   = rd_len;
                                end
                                if (!n_found_reg &&
                                    SIZE_W'(rd_off) == SIZE_W'(e_off_reg) + SIZE_W'(e_len_reg))
                                begin
                                    n_found_next = 1'b1;
                                    n_idx_next   = eval_idx_reg;
                                    n_off_next   = rd_off;
                                    n_len_next   = rd_len;
                                end
                            end
                        end
                        default:
                        begin
                            // Renumbering: slots at the previous minimum age get the
                            // current rank, the rest compete for the next minimum.
                            if (vld && !done_reg[eval_idx_reg])
                            begin
                                if (have_m_reg && age_eff == m_reg)
                                begin
                                    age_we     = 1'b1;
                                    age_waddr  = eval_idx_reg;
                                    age_wdata  = AGE_W'(base_reg);
                                    aged_next[eval_idx_reg] = 1'b1;
                                    done_next[eval_idx_reg] = 1'b1;
                                    k_next     = k_reg + CNT_W'(1);
                                end
                                else if (!min_found_reg || age_eff < min_age_reg)
                                begin
                                    min_found_next = 1'b1;
                                    min_age_next   = age_eff;
                                end
                            end
                        end
                    endcase
                end
                if (pass_end)
                begin
                    state_next = after_reg;
                end
            end

            S_FOUND:
            begin
                if (!e_found_reg)
                begin
                    res_status_next = STAT_UNKNOWN_ADDR;
                    state_next      = S_RESULT;
                end
                else if (op_reg == OP_FREE || zero_reg)
                begin
                    start_pass = 1'b1;
                    mode_next  = PASS_NEIGH;
                    after_next = S_FREE_MERGE;
                    state_next = S_SCAN;
                end
                else if (s_reg == SIZE_W'(e_len_reg))
                begin
                    res_addr_next = e_off_reg;
                    state_next    = S_RESULT;
                end
                else if (s_reg < SIZE_W'(e_len_reg))
                begin
                    if (!spare_found_reg)
                    begin
                        res_status_next = STAT_TABLE_FULL;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        valid_next[spare_idx_reg] = 1'b1;
                        free_next[spare_idx_reg]  = 1'b1;
                        age_ret_next = S_SHRINK_W1;
                        state_next   = S_AGE;
                    end
                end
                else
                begin
                    start_pass = 1'b1;
                    mode_next  = PASS_NEIGH;
                    after_next = S_GROW_DEC;
                    state_next = S_SCAN;
                end
            end

            S_ALLOC_DEC:
            begin
                if (!best_found_reg)
                begin
                    res_status_next = STAT_NO_FIT;
                    res_addr_next   = '0;
                    state_next      = S_RESULT;
                end
                else if (SIZE_W'(best_len_reg) == s_reg)
                begin
                    free_next[best_idx_reg] = 1'b0;
                    age_ret_next = S_EXACT;
                    state_next   = S_AGE;
                end
                else if (!spare_found_reg)
                begin
                    res_status_next = STAT_TABLE_FULL;
                    res_addr_next   = '0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    valid_next[spare_idx_reg] = 1'b1;
                    free_next[spare_idx_reg]  = 1'b0;
                    age_ret_next = S_SPLIT_W1;
                    state_next   = S_AGE;
                end
            end

            S_AGE:
            begin
                if (next_age_reg >= AGE_LIMIT)
                begin
                    done_next   = '0;
                    have_m_next = 1'b0;
                    k_next      = '0;
                    base_next   = '0;
                    start_pass  = 1'b1;
                    mode_next   = PASS_RANK;
                    after_next  = S_RANK_END;
                    state_next  = S_SCAN;
                end
                else
                begin
                    age_val_next  = next_age_reg;
                    next_age_next = next_age_reg + AGE_W'(1);
                    state_next    = age_ret_reg;
                end
            end

            S_RANK_END:
            begin
                if (min_found_reg)
                begin
                    have_m_next = 1'b1;
                    m_next      = min_age_reg;
                    base_next   = k_reg;
                    start_pass  = 1'b1;
                    state_next  = S_SCAN;
                end
                else
                begin
                    next_age_next = AGE_W'(k_reg);
                    state_next    = S_AGE;
                end
            end

            S_EXACT, S_SPLIT_W2:
            begin
                if (state_reg == S_EXACT)
                begin
                    age_we    = 1'b1;
                    age_waddr = best_idx_reg;
                    age_wdata = age_val_reg;
                    aged_next[best_idx_reg] = 1'b1;
                end
                else
                begin
                    ol_we    = 1'b1;
                    ol_waddr = best_idx_reg;
                    ol_wdata = {best_off_reg + OFF_W'(s_reg), best_len_reg - LEN_W'(s_reg)};
                end
                do_add        = 1'b1;
                add_amt       = LEN_W'(s_reg);
                res_addr_next = best_off_reg;
                if (move_reg)
                begin
                    // A moved block releases its old place afterwards.
                    start_pass = 1'b1;
                    mode_next  = PASS_NEIGH;
                    after_next = S_FREE_MERGE;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_SPLIT_W1:
            begin
                ol_we     = 1'b1;
                ol_waddr  = spare_idx_reg;
                ol_wdata  = {best_off_reg, LEN_W'(s_reg)};
                age_we    = 1'b1;
                age_waddr = spare_idx_reg;
                age_wdata = age_val_reg;
                aged_next[spare_idx_reg] = 1'b1;
                state_next = S_SPLIT_W2;
            end

            S_SHRINK_W1:
            begin
                ol_we     = 1'b1;
                ol_waddr  = spare_idx_reg;
                ol_wdata  = {e_off_reg + OFF_W'(s_reg), e_len_reg - LEN_W'(s_reg)};
                age_we    = 1'b1;
                age_waddr = spare_idx_reg;
                age_wdata = age_val_reg;
                aged_next[spare_idx_reg] = 1'b1;
                state_next = S_SHRINK_W2;
            end

            S_SHRINK_W2:
            begin
                ol_we         = 1'b1;
                ol_waddr      = e_idx_reg;
                ol_wdata      = {e_off_reg, LEN_W'(s_reg)};
                do_sub        = 1'b1;
                sub_amt       = e_len_reg - LEN_W'(s_reg);
                res_addr_next = e_off_reg;
                state_next    = S_RESULT;
            end

            S_FREE_MERGE:
            begin
                do_sub  = 1'b1;
                sub_amt = e_len_reg;
                free_next[e_idx_reg] = 1'b1;
                merged_len = e_len_reg;
                if (p_ok)
                begin
                    merged_len = merged_len + p_len_reg;
                    valid_next[p_idx_reg] = 1'b0;
                end
                if (n_ok)
                begin
                    merged_len = merged_len + n_len_reg;
                    valid_next[n_idx_reg] = 1'b0;
                end
                ol_we    = 1'b1;
                ol_waddr = e_idx_reg;
                ol_wdata = {p_ok ? p_off_reg : e_off_reg, merged_len};
                res_status_next = STAT_OK;
                res_moved_next  = move_reg;
                res_addr_next   = move_reg ? res_addr_reg : '0;
                state_next      = S_RESULT;
            end

            S_GROW_DEC:
            begin
                if (p_ok && SIZE_W'(p_len_reg) >= diff)
                begin
                    ol_we          = 1'b1;
                    ol_waddr       = e_idx_reg;
                    ol_wdata       = {e_off_reg - OFF_W'(diff), LEN_W'(s_reg)};
                    do_add         = 1'b1;
                    add_amt        = LEN_W'(diff);
                    res_addr_next  = e_off_reg - OFF_W'(diff);
                    res_moved_next = 1'b1;
                    grow_p_next    = 1'b1;
                    state_next     = S_GROW_W2;
                end
                else if (n_ok && SIZE_W'(n_len_reg) >= diff)
                begin
                    ol_we          = 1'b1;
                    ol_waddr       = e_idx_reg;
                    ol_wdata       = {e_off_reg, LEN_W'(s_reg)};
                    do_add         = 1'b1;
                    add_amt        = LEN_W'(diff);
                    res_addr_next  = e_off_reg;
                    grow_p_next    = 1'b0;
                    state_next     = S_GROW_W2;
                end
                else
                begin
                    move_next = 1'b1;
                    if (s_reg > SIZE_W'(pool))
                    begin
                        res_status_next = STAT_TOO_LARGE;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        start_pass = 1'b1;
                        mode_next  = PASS_BEST;
                        after_next = S_ALLOC_DEC;
                        state_next = S_SCAN;
                    end
                end
            end

            S_GROW_W2:
            begin
                ol_we = 1'b1;
                if (grow_p_reg)
                begin
                    ol_waddr = p_idx_reg;
                    ol_wdata = {p_off_reg, p_len_reg - LEN_W'(diff)};
                    if (SIZE_W'(p_len_reg) == diff)
                    begin
                        valid_next[p_idx_reg] = 1'b0;
                    end
                end
                else
                begin
                    ol_waddr = n_idx_reg;
                    ol_wdata = {n_off_reg + OFF_W'(diff), n_len_reg - LEN_W'(diff)};
                    if (SIZE_W'(n_len_reg) == diff)
                    begin
                        valid_next[n_idx_reg] = 1'b0;
                    end
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (start_pass)
        begin
            scan_idx_next    = '0;
            e_found_next     = 1'b0;
            spare_found_next = 1'b0;
            best_found_next  = 1'b0;
            p_found_next     = 1'b0;
            n_found_next     = 1'b0;
            min_found_next   = 1'b0;
        end

        if (do_add)
        begin
            sum       = used_reg + add_amt;
            used_next = sum;
            if (sum > peak_reg)
            begin
                peak_next = sum;
            end
        end
        if (do_sub)
        begin
            used_next = (used_reg >= sub_amt) ? used_reg - sub_amt : '0;
        end

        if (cfg_write)
        begin
            state_next    = S_IDLE;
            init_next     = 1'b1;
            valid_next    = '0;
            free_next     = '0;
            aged_next     = '0;
            used_next     = '0;
            peak_next     = '0;
            next_age_next = AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            after_reg       <= S_IDLE;
            age_ret_reg     <= S_IDLE;
            mode_reg        <= PASS_FIND_USED;
            init_reg        <= 1'b1;
            move_reg        <= 1'b0;
            scan_idx_reg    <= '0;
            eval_en_reg     <= 1'b0;
            e_found_reg     <= 1'b0;
            spare_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            p_found_reg     <= 1'b0;
            n_found_reg     <= 1'b0;
            have_m_reg      <= 1'b0;
            min_found_reg   <= 1'b0;
            k_reg           <= '0;
            base_reg        <= '0;
            next_age_reg    <= AGE_W'(1);
            used_reg        <= '0;
            peak_reg        <= '0;
            valid_reg       <= '0;
            free_reg        <= '0;
            aged_reg        <= '0;
            done_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            after_reg       <= after_next;
            age_ret_reg     <= age_ret_next;
            mode_reg        <= mode_next;
            init_reg        <= init_next;
            move_reg        <= move_next;
            scan_idx_reg    <= scan_idx_next;
            eval_en_reg     <= eval_en_next;
            e_found_reg     <= e_found_next;
            spare_found_reg <= spare_found_next;
            best_found_reg  <= best_found_next;
            p_found_reg     <= p_found_next;
            n_found_reg     <= n_found_next;
            have_m_reg      <= have_m_next;
            min_found_reg   <= min_found_next;
            k_reg           <= k_next;
            base_reg        <= base_next;
            next_age_reg    <= next_age_next;
            used_reg        <= used_next;
            peak_reg        <= peak_next;
            valid_reg       <= valid_next;
            free_reg        <= free_next;
            aged_reg        <= aged_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        s_reg          <= s_next;
        addr_reg       <= addr_next;
        zero_reg       <= zero_next;
        grow_p_reg     <= grow_p_next;
        eval_idx_reg   <= eval_idx_next;
        e_idx_reg      <= e_idx_next;
        e_off_reg      <= e_off_next;
        e_len_reg      <= e_len_next;
        spare_idx_reg  <= spare_idx_next;
        best_idx_reg   <= best_idx_next;
        best_off_reg   <= best_off_next;
        best_len_reg   <= best_len_next;
        best_age_reg   <= best_age_next;
        p_idx_reg      <= p_idx_next;
        p_off_reg      <= p_off_next;
        p_len_reg      <= p_len_next;
        n_idx_reg      <= n_idx_next;
        n_off_reg      <= n_off_next;
        n_len_reg      <= n_len_next;
        m_reg          <= m_next;
        min_age_reg    <= min_age_next;
        age_val_reg    <= age_val_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_moved_reg  <= res_moved_next;
    end

    assign init_busy             = init_reg;
    assign done                  = (state_reg == S_RESULT);
    assign result.status         = res_status_reg;
    assign result.result_address = (res_status_reg == STAT_OK) ? res_addr_reg : '0;
    assign result.moved          = (res_status_reg == STAT_OK) ? res_moved_reg : 1'b0;
    assign result.used_bytes     = used_reg;
    assign result.peak_bytes     = peak_reg;

endmodule

`default_nettype wire

### sv/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: config register, front end,
// job queue and table engine. Depends on ffba_pkg, ffba_front, ffba_queue, ffba_back.
//
//   Channel   Signals                      Transfer when
//   --------  ---------------------------  ------------------------------
//   request   start, busy, request         start high and busy low
//   result    done, result                 done high (one cycle, no stall)
//   config    cfg_write, cfg_data          cfg_write high
//
// A request costs one pass over the 64-slot table per search, each pass
// going through the single read port of the table memories. Once in about
// 65000 age stamps the ages are renumbered, which takes up to 65 passes.
// After reset and after each config write the engine writes the initial
// free segment before it takes jobs; busy is high meanwhile. Busy is also
// high while the two-entry job queue is full. Results cannot be stalled.
`default_nettype none

module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire request_t        request,
    output logic                 done,
    output result_t              result,
    input  wire logic            cfg_write,
    input  wire logic [KB_W-1:0] cfg_data
);

    // Pool size register; the table is rebuilt from it whenever it is written.
    logic [KB_W-1:0]  pool_kb_reg;
    logic [LEN_W-1:0] pool;
    logic             push;
    logic             pop;
    logic             init_busy;
    job_t             push_job;
    job_t             head;
    q_status_t        qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_kb_reg <= KB_W'(POOL_KB_RESET);
        end
        else if (cfg_write)
        begin
            pool_kb_reg <= cfg_data;
        end
    end

    assign pool = pool_bytes(pool_kb_reg);

    // The front end rounds and classifies each request transfer.
    ffba_front u_front (
        .start     (start),
        .request   (request),
        .qstat     (qstat),
        .init_busy (init_busy),
        .busy      (busy),
        .push      (push),
        .job       (push_job)
    );

    // Short queue so requests can be taken while the engine is scanning.
    ffba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // The engine walks the segment table and produces one result per job.
    ffba_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .pool      (pool),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .init_busy (init_busy),
        .done      (done),
        .result    (result)
    );

    // After every result the engine returns to idle before the next result.
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on two cycles in a row");

    // Peak use never trails current use.
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.used_bytes <= result.peak_bytes))
        else $error("used bytes above peak bytes");

    // Rebuilding the table holds off new requests.
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> busy)
        else $error("request port open while the table is rebuilt");

    // Failed requests report no address and no move.
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STAT_OK) |->
            (result.result_address == '0 && !result.moved))
        else $error("error result carries an address");

endmodule

`default_nettype wire
